// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every check samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fscull assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fscull assertion failed");

`endif

// ===== rtl/core/fscull_pkg.sv =====
package fscull_pkg;

  localparam int NUM_PLANES   = 6;
  localparam int COORD_WIDTH  = 32;
  localparam int FRAC_BITS    = 16;
  localparam int FIELD_WIDTH  = 32;
  localparam int INDEX_WIDTH  = 3;
  localparam int PROD_WIDTH   = 2 * COORD_WIDTH;
  localparam int DMR_WIDTH    = COORD_WIDTH + 1;
  localparam int SUM_WIDTH    = PROD_WIDTH + 3;
  localparam int IN_DATA_W    = 8 * FIELD_WIDTH;
  localparam int IN_USER_W    = 1 + INDEX_WIDTH;
  localparam int OUT_DATA_W   = 8;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [DMR_WIDTH-1:0]   dmr_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;

  // One item moving along the chain. A load carries a, b, c, d in w0..w3;
  // a test carries x, y, z and the radius there.
  typedef struct packed {
    logic                   valid;
    op_t                    op;
    logic [INDEX_WIDTH-1:0] idx;
    coord_t                 w0;
    coord_t                 w1;
    coord_t                 w2;
    coord_t                 w3;
    logic                   in_frustum;
  } token_t;

  typedef struct packed {
    token_t tok;
    prod_t  prod_x;
    prod_t  prod_y;
    prod_t  prod_z;
    dmr_t   dmr;
  } mult_stage_t;

endpackage

// ===== rtl/core/fscull_cell.sv =====
`include "assert_macros.svh"

module fscull_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              sel,
  input  fscull_pkg::token_t tok_in,
  output fscull_pkg::token_t tok_out
);
  import fscull_pkg::*;

  coord_t      coef_a;
  coord_t      coef_b;
  coord_t      coef_c;
  coord_t      coef_d;
  mult_stage_t ms;
  mult_stage_t ms_next;
  token_t      ts;
  token_t      ts_next;
  logic        load_hit;
  sum_t        dist_sum;
  logic        exceed;

  assign load_hit = tok_in.valid && (tok_in.op == OP_LOAD) && sel;

  // The plane is captured together with the item, so a later load cannot
  // reach back into a test already inside this cell.
  always_comb begin
    ms_next.tok    = tok_in;
    ms_next.prod_x = $signed(tok_in.w0) * $signed(coef_a);
    ms_next.prod_y = $signed(tok_in.w1) * $signed(coef_b);
    ms_next.prod_z = $signed(tok_in.w2) * $signed(coef_c);
    ms_next.dmr    = $signed({coef_d[COORD_WIDTH-1], coef_d})
                   - $signed({tok_in.w3[COORD_WIDTH-1], tok_in.w3});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= '0;
      coef_b <= '0;
      coef_c <= '0;
      coef_d <= '0;
    end else if (en && load_hit) begin
      coef_a <= tok_in.w0;
      coef_b <= tok_in.w1;
      coef_c <= tok_in.w2;
      coef_d <= tok_in.w3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms.tok.valid <= 1'b0;
    end else if (en) begin
      ms <= ms_next;
    end
  end

  // Distance minus radius, all at Q32.32 and full width.
  always_comb begin
    dist_sum = sum_t'($signed(ms.prod_x)) + sum_t'($signed(ms.prod_y))
             + sum_t'($signed(ms.prod_z))
             + sum_t'($signed({ms.dmr, {FRAC_BITS{1'b0}}}));
    exceed = !dist_sum[SUM_WIDTH-1] && (dist_sum != '0);
  end

  always_comb begin
    ts_next            = ms.tok;
    ts_next.in_frustum = ms.tok.in_frustum && !((ms.tok.op == OP_TEST) && exceed);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ts.valid <= 1'b0;
    end else if (en) begin
      ts <= ts_next;
    end
  end

  assign tok_out = ts;

  `FSC_ASSERT_NEXT(a_coef_hold, !(en && load_hit),
    $stable(coef_a) && $stable(coef_b) && $stable(coef_c) && $stable(coef_d))
  `FSC_ASSERT_NEXT(a_outside_sticks, en && ms.tok.valid && !ms.tok.in_frustum,
    !ts.in_frustum)
  `FSC_ASSERT_NEXT(a_valid_moves, en, ts.valid == $past(ms.tok.valid))

endmodule

// ===== rtl/core/frustum_sphere_cull_test_core.sv =====
// Items pass from cell to cell; a test then goes through the output register to reach m_axis.
// Throughput: one transaction per cycle, loads and tests alike, unless the chain halts; each
// plane cell multiplies, then adds and compares, in two registered steps.
// Reset (rst, synchronous, active high) clears every plane to zero and empties the chain
// and the output register; s_axis_tready is high again in the cycle after reset.
`include "assert_macros.svh"

module frustum_sphere_cull_test_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0 up: plane_a, plane_b, plane_c, plane_d,
  // center_x, center_y, center_z, sphere_radius (32 bits each).
  input  logic [fscull_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0 up: opcode (1 bit), plane_index (3 bits).
  input  logic [fscull_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0 up: inside_res (1 bit), then zero fill.
  output logic [fscull_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import fscull_pkg::*;

  // chain[0] is the incoming item; chain[k+1] is what cell k hands on.
  token_t                 chain [NUM_PLANES+1];
  logic [NUM_PLANES-1:0]  sel;
  logic                   advance;
  logic                   last_is_test;
  logic                   out_valid;
  logic                   out_inside;
  op_t                    in_op;
  logic [FIELD_WIDTH-1:0] fld [8];

  // Unpack tdata into its eight 32-bit fields.
  for (genvar f = 0; f < 8; f++) begin : g_field
    assign fld[f] = s_axis_tdata[f*FIELD_WIDTH +: FIELD_WIDTH];
  end

  assign in_op = op_t'(s_axis_tuser[0]);

  // The whole chain moves in lockstep. It halts only when a finished test
  // reaches the end while the output register still holds an untaken result;
  // loads and empty slots simply fall off the end.
  assign last_is_test = chain[NUM_PLANES].valid && (chain[NUM_PLANES].op == OP_TEST);
  assign advance      = !(last_is_test && out_valid && !m_axis_tready);
  assign s_axis_tready = advance;

  // A load and a test share the four data words of a chain item, so the
  // cells only ever see one set of operands.
  always_comb begin
    chain[0].valid      = s_axis_tvalid && advance;
    chain[0].op         = in_op;
    chain[0].idx        = s_axis_tuser[IN_USER_W-1:1];
    chain[0].in_frustum = 1'b1;
    if (in_op == OP_LOAD) begin
      chain[0].w0 = fld[0][COORD_WIDTH-1:0];
      chain[0].w1 = fld[1][COORD_WIDTH-1:0];
      chain[0].w2 = fld[2][COORD_WIDTH-1:0];
      chain[0].w3 = fld[3][COORD_WIDTH-1:0];
    end else begin
      chain[0].w0 = fld[4][COORD_WIDTH-1:0];
      chain[0].w1 = fld[5][COORD_WIDTH-1:0];
      chain[0].w2 = fld[6][COORD_WIDTH-1:0];
      chain[0].w3 = fld[7][COORD_WIDTH-1:0];
    end
  end

  // Each cell owns one plane. A load updates its cell as it passes by, so
  // tests ahead of it still see the old plane and tests behind see the new one.
  // A load whose index names no cell passes through and changes nothing.
  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
    assign sel[k] = (int'(chain[k].idx) == k);

    fscull_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (advance),
      .sel     (sel[k]),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  // Output register: holds one result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_is_test) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_is_test) begin
      out_inside <= chain[NUM_PLANES].in_frustum;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_inside};

  `FSC_ASSERT_NOW(a_stall_on_full, last_is_test && out_valid && !m_axis_tready,
    !s_axis_tready)
  `FSC_ASSERT_NEXT(a_result_lands, advance && last_is_test, m_axis_tvalid)
  `FSC_ASSERT_NOW(a_empty_after_reset, $past(rst), !m_axis_tvalid)

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fscull_pkg::*;

  // A test transaction needs one multiply step and one add/compare step in each
  // plane cell, plus the output register.
  localparam int PIPE_DEPTH   = 2 * NUM_PLANES + 1;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 900;

  // Handy Q16.16 constants.
  localparam coord_t Q_ONE = 32'sh0001_0000;
  localparam coord_t Q_TEN = 32'sh000A_0000;
  localparam coord_t Q_MAX = 32'sh7FFF_FFFF;
  localparam coord_t Q_MIN = 32'sh8000_0000;

  // One input transaction as the testbench sees it, before packing.
  typedef struct {
    op_t                    op;
    logic [INDEX_WIDTH-1:0] idx;
    coord_t                 a, b, c, d;
    coord_t                 x, y, z, r;
  } cull_item_t;

  // Keeps a private copy of the plane table and a queue of inside verdicts
  // that the block still owes.
  class cull_scoreboard;
    coord_t planes [NUM_PLANES][4];
    bit     inside_expected [$];
    int     errors;

    function new();
      errors = 0;
      foreach (planes[p, k]) planes[p][k] = '0;
    endfunction

    // Exact distance a*x + b*y + c*z + d per plane, compared with the radius.
    // The 128-bit signed sum cannot overflow for 32-bit operands.
    function bit predict_inside(coord_t x, coord_t y, coord_t z, coord_t r);
      logic signed [127:0] dist_sum;
      logic signed [127:0] bound;
      bit                  verdict;
      verdict = 1'b1;
      bound   = longint'(r) <<< FRAC_BITS;
      for (int p = 0; p < NUM_PLANES; p++) begin
        dist_sum = longint'(planes[p][0]) * longint'(x);
        dist_sum = dist_sum + longint'(planes[p][1]) * longint'(y);
        dist_sum = dist_sum + longint'(planes[p][2]) * longint'(z);
        dist_sum = dist_sum + (longint'(planes[p][3]) <<< FRAC_BITS);
        if (dist_sum > bound) verdict = 1'b0;
      end
      return verdict;
    endfunction

    function void note_input(cull_item_t it);
      if (it.op == OP_LOAD) begin
        // Loads past the last plane are dropped by the block.
        if (it.idx < NUM_PLANES) begin
          planes[it.idx][0] = it.a;
          planes[it.idx][1] = it.b;
          planes[it.idx][2] = it.c;
          planes[it.idx][3] = it.d;
        end
      end else begin
        inside_expected.push_back(predict_inside(it.x, it.y, it.z, it.r));
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] got);
      logic [OUT_DATA_W-1:0] want;
      if (inside_expected.size() == 0) begin
        $display("%0t: result arrived with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = {{(OUT_DATA_W-1){1'b0}}, inside_expected.pop_front()};
      if (got[0] !== want[0]) begin
        $display("%0t: inside_res mismatch, expected %0d actual %0d",
                 $time, want[0], got[0]);
        errors++;
      end
      if (got[OUT_DATA_W-1:1] !== want[OUT_DATA_W-1:1]) begin
        $display("%0t: zero fill mismatch, expected %h actual %h",
                 $time, want[OUT_DATA_W-1:1], got[OUT_DATA_W-1:1]);
        errors++;
      end
    endfunction

    function int pending();
      return inside_expected.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  cull_scoreboard sb;
  int             cycle_count = 0;
  int             burst_left  = 0;

  frustum_sphere_cull_test_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding",
               $time, sb.pending());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Output monitor. The values read right after the edge are the ones the
  // block saw at that edge, so a transaction is counted exactly once.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Receiver backpressure: runs of ready and stall of random length, with a
  // long always-ready stretch every sixth run so the pipeline can stream.
  initial begin
    int run_no;
    int hi_len;
    int lo_len;
    run_no        = 0;
    m_axis_tready = 1'b0;
    forever begin
      run_no++;
      if (run_no % 6 == 0) begin
        hi_len = 60;
        lo_len = 0;
      end else begin
        hi_len = $urandom_range(1, 12);
        lo_len = $urandom_range(1, 4);
      end
      repeat (hi_len) begin
        @(negedge clk);
        m_axis_tready <= 1'b1;
      end
      repeat (lo_len) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
      end
    end
  end

  // Random signed value in [-span, span], in raw Q16.16 units.
  function automatic coord_t rand_near(int span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Load transaction; the center fields are don't-care and carry noise.
  function automatic cull_item_t make_load(int idx, coord_t a, coord_t b, coord_t c,
                                           coord_t d);
    cull_item_t it;
    it.op  = OP_LOAD;
    it.idx = idx[INDEX_WIDTH-1:0];
    it.a   = a;
    it.b   = b;
    it.c   = c;
    it.d   = d;
    it.x   = $urandom();
    it.y   = $urandom();
    it.z   = $urandom();
    it.r   = $urandom();
    return it;
  endfunction

  // Test transaction; the plane fields and index are ignored and carry noise.
  function automatic cull_item_t make_test(coord_t x, coord_t y, coord_t z, coord_t r);
    cull_item_t it;
    it.op  = OP_TEST;
    it.idx = INDEX_WIDTH'($urandom_range(0, 7));
    it.a   = $urandom();
    it.b   = $urandom();
    it.c   = $urandom();
    it.d   = $urandom();
    it.x   = x;
    it.y   = y;
    it.z   = z;
    it.r   = r;
    return it;
  endfunction

  // Drive tvalid low, starting each idle cycle at its own falling edge.
  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // Present one transaction and hold it until the block takes it. The sender
  // works in bursts; a gap is inserted whenever a burst runs out, and a gap
  // of zero gives back-to-back bursts.
  task automatic send_item(cull_item_t it);
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1:    idle_cycles(0);
        7:       idle_cycles($urandom_range(12, 20));
        default: idle_cycles($urandom_range(1, 4));
      endcase
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {it.idx, it.op};
    s_axis_tdata  <= {it.r, it.z, it.y, it.x, it.d, it.c, it.b, it.a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(it);
  endtask

  // Stop sending until every owed verdict is back and the chain is empty.
  task automatic drain_pipeline();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  initial begin
    cull_item_t it;
    int         sent;
    int         idx;
    coord_t     ra, rb, rc, rd, cx, cy, cz, rr;

    sb            = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. With the table still at reset every distance is zero,
    // so only the sign of the radius decides.
    send_item(make_test(Q_MAX, Q_MIN, 32'sd0, 32'sd0));
    send_item(make_test(Q_MIN, Q_MAX, Q_ONE, -32'sd1));
    send_item(make_test(Q_MAX, Q_MAX, Q_MAX, Q_MIN));
    send_item(make_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX));
    // Loads to nonexistent planes must leave the table untouched.
    send_item(make_load(6, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_item(make_load(7, Q_MIN, Q_MIN, Q_MIN, Q_MAX));
    send_item(make_test(Q_ONE, Q_ONE, Q_ONE, 32'sd0));
    // An axis-aligned box of half-width ten: each plane is +-axis - 10.
    send_item(make_load(0, Q_ONE, 32'sd0, 32'sd0, -Q_TEN));
    send_item(make_load(1, -Q_ONE, 32'sd0, 32'sd0, -Q_TEN));
    send_item(make_load(2, 32'sd0, Q_ONE, 32'sd0, -Q_TEN));
    send_item(make_load(3, 32'sd0, -Q_ONE, 32'sd0, -Q_TEN));
    send_item(make_load(4, 32'sd0, 32'sd0, Q_ONE, -Q_TEN));
    send_item(make_load(5, 32'sd0, 32'sd0, -Q_ONE, -Q_TEN));
    // Point tests: center, exactly on a face, one LSB beyond it.
    send_item(make_test(32'sd0, 32'sd0, 32'sd0, 32'sd0));
    send_item(make_test(Q_TEN, 32'sd0, 32'sd0, 32'sd0));
    send_item(make_test(Q_TEN + 32'sd1, 32'sd0, 32'sd0, 32'sd0));
    // Sphere tests on either side of touching the face.
    send_item(make_test(Q_TEN + 32'sd1, 32'sd0, 32'sd0, 32'sd1));
    send_item(make_test(32'sh000C_0000, 32'sd0, 32'sd0, 32'sh0002_0000));
    send_item(make_test(32'sh000C_0000, 32'sd0, 32'sd0, 32'sh0001_FFFF));
    // Negative radius: inside only while every distance is at most the radius.
    send_item(make_test(32'sd0, 32'sd0, 32'sd0, -Q_TEN));
    send_item(make_test(32'sd0, 32'sd0, 32'sd0, -Q_TEN - 32'sd1));
    // Extreme coefficients against extreme centers exercise the full-width sum.
    send_item(make_load(0, Q_MIN, Q_MIN, Q_MIN, Q_MAX));
    send_item(make_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX));
    send_item(make_load(0, Q_MAX, Q_MAX, Q_MAX, Q_MIN));
    send_item(make_test(Q_MIN, Q_MIN, Q_MIN, Q_MIN));

    // Random part. Most loads build sensible planes (unit-scale normals and a
    // negative offset) so that nearby centers land on both sides; the rest are
    // raw 32-bit noise, and a few aim at plane slots that do not exist.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == RANDOM_ITEMS / 2) drain_pipeline();
      if ($urandom_range(0, 99) < 22) begin
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_PLANES, 7)
                                          : $urandom_range(0, NUM_PLANES - 1);
        if ($urandom_range(0, 3) == 0) begin
          ra = $urandom();
          rb = $urandom();
          rc = $urandom();
          rd = $urandom();
        end else begin
          ra = rand_near(Q_ONE);
          rb = rand_near(Q_ONE);
          rc = rand_near(Q_ONE);
          rd = -coord_t'($urandom_range(0, 20 * Q_ONE));
        end
        send_item(make_load(idx, ra, rb, rc, rd));
        if (idx < NUM_PLANES) sent++;
      end else begin
        if ($urandom_range(0, 4) == 0) begin
          cx = $urandom();
          cy = $urandom();
          cz = $urandom();
        end else begin
          cx = rand_near(16 * Q_ONE);
          cy = rand_near(16 * Q_ONE);
          cz = rand_near(16 * Q_ONE);
        end
        case ($urandom_range(0, 5))
          0:       rr = 32'sd0;
          1:       rr = $urandom();
          2:       rr = -coord_t'($urandom_range(1, 4 * Q_ONE));
          default: rr = coord_t'($urandom_range(0, 4 * Q_ONE));
        endcase
        send_item(make_test(cx, cy, cz, rr));
        sent++;
      end
    end

    // Wind down: wait for every owed verdict, then give the chain time to
    // show any stray result.
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
